[hdl/ltd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ltd_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_FRAME_LENGTH = 2'd0,
		REG_MAX_FRAME_LENGTH = 2'd1
	} cfg_reg_t;

	localparam logic [CFG_DATA_W-1:0] MIN_FRAME_LENGTH_RST = 24'd2;
	localparam logic [CFG_DATA_W-1:0] MAX_FRAME_LENGTH_RST = 24'd65536;

	typedef enum logic [3:0] {
		PH_LENGTH  = 4'b0001,
		PH_TYPE    = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_HALT    = 4'b1000
	} phase_t;

endpackage

`default_nettype wire

[hdl/ltd_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ltd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

interface ltd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic [15:0] frame_type;
	logic        last_of_frame;
	logic        empty_frame;
	logic        length_error;

	modport source (output valid, output payload_byte, output frame_type,
		output last_of_frame, output empty_frame, output length_error, input ready);
	modport sink (input valid, input payload_byte, input frame_type,
		input last_of_frame, input empty_frame, input length_error, output ready);
endinterface

interface ltd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ltd_pkg::CFG_IDX_W-1:0]  index;
	logic [ltd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/length_type_deframer.sv]
// Channel  Dir  Contents
// rx       in   stream_byte, one stream byte per beat
// tx       out  payload_byte, frame_type, last_of_frame, empty_frame, length_error
// cfg      in   index, data; write to min or max frame length
//
// A new byte is accepted every clock unless a pending result holds rx.
// Results sit in a single output register, and rx stays ready while that
// register is empty or being drained in the same cycle, so a stall on tx
// holds rx only while a result is pending. The cfg port is always ready.
// Reset clears the phase and counters and restores the default bounds; after
// a length error the block drops every byte until reset.
`timescale 1ns / 1ps
`default_nettype none

module length_type_deframer #(
	parameter int LEN_FIELD_BYTES  = 4,
	parameter int TYPE_FIELD_BYTES = 2,
	parameter int COUNT_BITS       = 24
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ltd_in_if.sink     rx,
	ltd_out_if.source  tx,
	ltd_cfg_if.sink    cfg
);

	localparam int LEN_W   = 8 * LEN_FIELD_BYTES;
	localparam int HDR_MAX = (LEN_FIELD_BYTES > TYPE_FIELD_BYTES) ?
		LEN_FIELD_BYTES : TYPE_FIELD_BYTES;
	localparam int CNT_W   = $clog2(HDR_MAX + 1);
	localparam logic [CNT_W-1:0] LEN_LAST  = CNT_W'(LEN_FIELD_BYTES - 1);
	localparam logic [CNT_W-1:0] TYPE_LAST = CNT_W'(TYPE_FIELD_BYTES - 1);
	localparam logic [33:0] PAY_LIMIT =
		(34'd1 << COUNT_BITS) - 34'd1 + 34'(TYPE_FIELD_BYTES);
	localparam int CFG_W_MIN = ltd_pkg::CFG_DATA_W;

	ltd_pkg::phase_t phase_q;
	logic [CNT_W-1:0] hdr_cnt_q;
	logic [LEN_W-1:0] len_q;
	logic [15:0] type_q;
	logic [COUNT_BITS-1:0] pay_rem_q;
	logic [CFG_W_MIN-1:0] min_len_q;
	logic [CFG_W_MIN-1:0] max_len_q;

	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic [15:0] out_type_q;
	logic out_last_q;
	logic out_empty_q;
	logic out_err_q;

	logic in_fire;
	logic [LEN_W-1:0] len_next;
	logic [31:0] len32;
	logic [15:0] type_next;
	logic len_bad;
	logic [COUNT_BITS-1:0] pay_init;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !out_valid_q || tx.ready;
	assign in_fire   = rx.valid && rx.ready;

	assign len_next  = LEN_W'({len_q, rx.stream_byte});
	assign len32     = 32'(len_next);
	assign type_next = {type_q[7:0], rx.stream_byte};
	assign pay_init  = COUNT_BITS'(len32 - 32'(TYPE_FIELD_BYTES));
	assign len_bad   = (len32 < 32'(min_len_q)) || (len32 > 32'(max_len_q)) ||
		(len32 < 32'(TYPE_FIELD_BYTES)) || ({2'b00, len32} > PAY_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= ltd_pkg::MIN_FRAME_LENGTH_RST;
			max_len_q <= ltd_pkg::MAX_FRAME_LENGTH_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				ltd_pkg::REG_MIN_FRAME_LENGTH: min_len_q <= cfg.data;
				ltd_pkg::REG_MAX_FRAME_LENGTH: max_len_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ltd_pkg::PH_LENGTH;
			hdr_cnt_q   <= '0;
			len_q       <= '0;
			type_q      <= '0;
			pay_rem_q   <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_type_q  <= '0;
			out_last_q  <= 1'b0;
			out_empty_q <= 1'b0;
			out_err_q   <= 1'b0;
		end else begin
			if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				case (phase_q)
					ltd_pkg::PH_LENGTH: begin
						len_q <= len_next;
						if (hdr_cnt_q != LEN_LAST) begin
							hdr_cnt_q <= hdr_cnt_q + 1'b1;
						end else begin
							hdr_cnt_q <= '0;
							if (len_bad) begin
								phase_q     <= ltd_pkg::PH_HALT;
								out_valid_q <= 1'b1;
								out_byte_q  <= '0;
								out_type_q  <= '0;
								out_last_q  <= 1'b0;
								out_empty_q <= 1'b0;
								out_err_q   <= 1'b1;
							end else begin
								pay_rem_q <= pay_init;
								type_q    <= '0;
								phase_q   <= ltd_pkg::PH_TYPE;
							end
						end
					end
					ltd_pkg::PH_TYPE: begin
						type_q <= type_next;
						if (hdr_cnt_q != TYPE_LAST) begin
							hdr_cnt_q <= hdr_cnt_q + 1'b1;
						end else begin
							hdr_cnt_q <= '0;
							if (pay_rem_q == '0) begin
								phase_q     <= ltd_pkg::PH_LENGTH;
								len_q       <= '0;
								out_valid_q <= 1'b1;
								out_byte_q  <= '0;
								out_type_q  <= type_next;
								out_last_q  <= 1'b1;
								out_empty_q <= 1'b1;
								out_err_q   <= 1'b0;
							end else begin
								phase_q <= ltd_pkg::PH_PAYLOAD;
							end
						end
					end
					ltd_pkg::PH_PAYLOAD: begin
						out_valid_q <= 1'b1;
						out_byte_q  <= rx.stream_byte;
						out_type_q  <= type_q;
						out_empty_q <= 1'b0;
						out_err_q   <= 1'b0;
						if (pay_rem_q <= COUNT_BITS'(1)) begin
							out_last_q <= 1'b1;
							pay_rem_q  <= '0;
							len_q      <= '0;
							phase_q    <= ltd_pkg::PH_LENGTH;
						end else begin
							out_last_q <= 1'b0;
							pay_rem_q  <= pay_rem_q - 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.payload_byte  = out_byte_q;
	assign tx.frame_type    = out_type_q;
	assign tx.last_of_frame = out_last_q;
	assign tx.empty_frame   = out_empty_q;
	assign tx.length_error  = out_err_q;

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ltd_pkg::PH_HALT |=> phase_q == ltd_pkg::PH_HALT)
		else $error("Deframer left the halt phase without reset.");

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q |-> phase_q == ltd_pkg::PH_HALT)
		else $error("Error result pending while not halted.");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ltd_pkg::PH_PAYLOAD |-> pay_rem_q != '0)
		else $error("Payload phase with no bytes remaining.");

	a_len_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ltd_pkg::PH_LENGTH |-> hdr_cnt_q <= LEN_LAST)
		else $error("Length byte count out of range.");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !tx.ready |=> out_valid_q && !$past(in_fire))
		else $error("Pending result overwritten during a stall.");

endmodule

`default_nettype wire

[tb/tb_length_type_deframer.sv]
`timescale 1ns / 1ps

module tb_length_type_deframer;

	localparam int LEN_BYTES = 4;
	localparam int TYPE_BYTES = 2;
	localparam logic [31:0] COUNT_MAX = 32'h00FF_FFFF;
	localparam logic [ltd_pkg::CFG_DATA_W-1:0] BOUND_TOP = 24'hFF_FFFF;
	localparam logic [ltd_pkg::CFG_DATA_W-1:0] BOUND_LOW = 24'd2;
	localparam logic [ltd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [ltd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int FILL_RANDOM = -1;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD = 200;
	localparam int TIMEOUT_NS = 20_000_000;

	typedef enum int {
		FAULT_BELOW_MIN,
		FAULT_ABOVE_MAX,
		FAULT_BELOW_TYPE,
		FAULT_CROSSED,
		FAULT_TOO_LONG
	} length_fault_t;

	typedef struct {
		logic [7:0]  payload_byte;
		logic [15:0] frame_type;
		logic        last_of_frame;
		logic        empty_frame;
		logic        length_error;
	} frame_beat_t;

	class deframe_scoreboard;
		ltd_pkg::phase_t phase;
		int          hdr_count;
		logic [31:0] len_acc;
		logic [15:0] type_acc;
		logic [23:0] remaining;
		logic [23:0] min_len;
		logic [23:0] max_len;
		frame_beat_t expected_q[$];
		int          errors;

		function new();
			phase = ltd_pkg::PH_LENGTH;
			hdr_count = 0;
			len_acc = '0;
			type_acc = '0;
			remaining = '0;
			min_len = ltd_pkg::MIN_FRAME_LENGTH_RST;
			max_len = ltd_pkg::MAX_FRAME_LENGTH_RST;
			errors = 0;
		endfunction

		function void push_beat(logic [7:0] b, logic [15:0] t, logic l, logic e, logic er);
			frame_beat_t r;
			r.payload_byte = b;
			r.frame_type = t;
			r.last_of_frame = l;
			r.empty_frame = e;
			r.length_error = er;
			expected_q.push_back(r);
		endfunction

		function void set_bound(logic [ltd_pkg::CFG_IDX_W-1:0] idx,
				logic [ltd_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				ltd_pkg::REG_MIN_FRAME_LENGTH: min_len = val;
				ltd_pkg::REG_MAX_FRAME_LENGTH: max_len = val;
				default: ;
			endcase
		endfunction

		function void take_byte(logic [7:0] b);
			logic last_beat;
			case (phase)
				ltd_pkg::PH_LENGTH: begin
					len_acc = {len_acc[23:0], b};
					hdr_count++;
					if (hdr_count == LEN_BYTES) begin
						hdr_count = 0;
						if (len_acc < {8'd0, min_len} || len_acc > {8'd0, max_len} ||
								len_acc < TYPE_BYTES || len_acc - TYPE_BYTES > COUNT_MAX) begin
							phase = ltd_pkg::PH_HALT;
							push_beat(8'd0, 16'd0, 1'b0, 1'b0, 1'b1);
						end else begin
							remaining = 24'(len_acc - TYPE_BYTES);
							type_acc = '0;
							phase = ltd_pkg::PH_TYPE;
						end
					end
				end
				ltd_pkg::PH_TYPE: begin
					type_acc = {type_acc[7:0], b};
					hdr_count++;
					if (hdr_count == TYPE_BYTES) begin
						hdr_count = 0;
						if (remaining == 0) begin
							phase = ltd_pkg::PH_LENGTH;
							len_acc = '0;
							push_beat(8'd0, type_acc, 1'b1, 1'b1, 1'b0);
						end else begin
							phase = ltd_pkg::PH_PAYLOAD;
						end
					end
				end
				ltd_pkg::PH_PAYLOAD: begin
					last_beat = (remaining <= 1);
					remaining = remaining - 1'b1;
					if (last_beat) begin
						remaining = '0;
						phase = ltd_pkg::PH_LENGTH;
						len_acc = '0;
					end
					push_beat(b, type_acc, last_beat, 1'b0, 1'b0);
				end
				default: ;
			endcase
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void compare_result(frame_beat_t got);
			frame_beat_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual byte %0h type %0h %b%b%b",
					$time, got.payload_byte, got.frame_type, got.last_of_frame,
					got.empty_frame, got.length_error);
			end else begin
				want = expected_q.pop_front();
				check_field("payload_byte", want.payload_byte, got.payload_byte);
				check_field("frame_type", want.frame_type, got.frame_type);
				check_field("last_of_frame", want.last_of_frame, got.last_of_frame);
				check_field("empty_frame", want.empty_frame, got.empty_frame);
				check_field("length_error", want.length_error, got.length_error);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit hold_req = 1'b0;
	bit idling = 1'b1;
	deframe_scoreboard sb = new();

	ltd_in_if rx_if();
	ltd_out_if tx_if();
	ltd_cfg_if cfg_if();

	length_type_deframer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.tx(tx_if),
		.cfg(cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb_length_type_deframer: FAIL");
		$finish;
	end

	always @(posedge clk) begin : monitor
		frame_beat_t got;
		if (arst_n) begin
			if (tx_if.valid && tx_if.ready) begin
				got.payload_byte = tx_if.payload_byte;
				got.frame_type = tx_if.frame_type;
				got.last_of_frame = tx_if.last_of_frame;
				got.empty_frame = tx_if.empty_frame;
				got.length_error = tx_if.length_error;
				sb.compare_result(got);
			end
			if (rx_if.valid && rx_if.ready)
				sb.take_byte(rx_if.stream_byte);
			if (cfg_if.valid && cfg_if.ready)
				sb.set_bound(cfg_if.index, cfg_if.data);
		end
	end

	initial begin : sink_side
		tx_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				tx_if.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (idling && $urandom_range(0, 7) == 0) begin
				tx_if.ready <= 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end else begin
				tx_if.ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (idling && $urandom_range(0, 7) == 0) begin
			rx_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.stream_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [31:0] len, input logic [15:0] ftype, input int fill);
		for (int i = LEN_BYTES - 1; i >= 0; i--)
			send_byte(len[8*i +: 8]);
		send_byte(ftype[15:8]);
		send_byte(ftype[7:0]);
		for (int unsigned i = TYPE_BYTES; i < len; i++)
			send_byte(fill == FILL_RANDOM ? 8'($urandom) : 8'(fill));
	endtask

	task automatic settle();
		rx_if.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ltd_pkg::CFG_IDX_W-1:0] idx,
			input logic [ltd_pkg::CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_bounds(input logic [ltd_pkg::CFG_DATA_W-1:0] lo,
			input logic [ltd_pkg::CFG_DATA_W-1:0] hi);
		settle();
		write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
			ltd_pkg::CFG_DATA_W'($urandom));
		write_reg(ltd_pkg::REG_MIN_FRAME_LENGTH, lo);
		write_reg(ltd_pkg::REG_MAX_FRAME_LENGTH, hi);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_frames(input int budget);
		int sent;
		int pick;
		logic [31:0] lo;
		logic [31:0] span;
		logic [31:0] cap;
		logic [31:0] len;
		sent = 0;
		while (sent < budget) begin
			lo = {8'd0, sb.min_len};
			span = {8'd0, sb.max_len} - lo;
			cap = (span > 40) ? 32'd40 : span;
			pick = $urandom_range(0, 9);
			if (pick == 0)
				len = lo;
			else if (pick == 1 && span <= 300)
				len = {8'd0, sb.max_len};
			else
				len = lo + $urandom_range(0, cap);
			send_frame(len, 16'($urandom), FILL_RANDOM);
			sent += LEN_BYTES + int'(len);
		end
	endtask

	task automatic send_bad_length();
		length_fault_t kind;
		logic [ltd_pkg::CFG_DATA_W-1:0] bound;
		logic [31:0] len;
		kind = length_fault_t'($urandom_range(0, 4));
		case (kind)
			FAULT_BELOW_MIN: begin
				bound = ltd_pkg::CFG_DATA_W'($urandom_range(3, 1000));
				program_bounds(bound, BOUND_TOP);
				len = $urandom_range(0, bound - 1);
			end
			FAULT_ABOVE_MAX: begin
				bound = ltd_pkg::CFG_DATA_W'($urandom_range(2, 1000));
				program_bounds(BOUND_LOW, bound);
				len = $urandom;
				if (len <= {8'd0, bound})
					len = {8'd0, bound} + 1;
			end
			FAULT_BELOW_TYPE: begin
				program_bounds(BOUND_LOW, BOUND_TOP);
				len = $urandom_range(0, 1);
			end
			FAULT_CROSSED: begin
				program_bounds(BOUND_TOP, BOUND_LOW);
				len = $urandom_range(2, BOUND_TOP);
			end
			default: begin
				program_bounds(BOUND_LOW, BOUND_TOP);
				len = 32'h0100_0000 | $urandom;
			end
		endcase
		for (int i = LEN_BYTES - 1; i >= 0; i--)
			send_byte(len[8*i +: 8]);
		repeat (16) send_byte(8'($urandom));
	endtask

	initial begin : stimulus
		logic [ltd_pkg::CFG_DATA_W-1:0] lo;
		rx_if.valid = 1'b0;
		rx_if.stream_byte = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = ltd_pkg::REG_MIN_FRAME_LENGTH;
		cfg_if.data = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_frame(32'd2, 16'h0000, FILL_RANDOM);
		send_frame(32'd3, 16'hFFFF, 8'hFF);
		send_frame(32'd4, 16'h8001, 8'h00);
		rx_if.valid <= 1'b0;
		@(posedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		run_frames(550);

		program_bounds(BOUND_TOP, BOUND_LOW);
		program_bounds(BOUND_LOW, BOUND_TOP);
		run_frames(500);

		lo = ltd_pkg::CFG_DATA_W'($urandom_range(2, 12));
		program_bounds(lo, lo);
		run_frames(350);

		lo = ltd_pkg::CFG_DATA_W'($urandom_range(2, 20));
		program_bounds(lo, ltd_pkg::CFG_DATA_W'(lo + $urandom_range(0, 60)));
		@(posedge clk);
		idling = 1'b0;
		@(negedge clk);
		run_frames(250);
		settle();
		run_frames(250);

		send_bad_length();
		settle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_length_type_deframer: PASS");
		else
			$display("tb_length_type_deframer: FAIL");
		$finish;
	end

endmodule
